// ===== src/psj_pkg.sv =====
// Package for the pulse segment joiner: transaction payload types, the
// command and status structs between controller and datapath, and constants.
// No dependencies.
package psj_pkg;

   localparam int SEGMENTS_DEFAULT = 8;
   localparam int JOIN_MIN_SEGMENTS = 4;
   localparam int JOIN_CHANGES = 2;

   typedef struct packed {
      logic        level_high;
      logic [15:0] pulse_period;
      logic [15:0] active_time;
   } psj_req_type;

   typedef struct packed {
      logic [15:0] joined_period;
      logic [15:0] joined_high;
      logic        overflow;
   } psj_rsp_type;

   typedef struct packed {
      logic capture;
      logic append_active;
      logic append_rest;
      logic walk_start;
      logic walk_step;
      logic emit_join;
      logic emit_overflow;
   } psj_cmd_type;

   typedef struct packed {
      logic full;
      logic join_ready;
      logic walk_stop;
      logic out_free;
   } psj_status_type;

endpackage

// ===== src/psj_ctrl.sv =====
// Controller state machine of the pulse segment joiner.
// Depends on psj_pkg for the command and status structs.
module psj_ctrl
   import psj_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  psj_status_type status,
   output psj_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_APPEND_ACTIVE,
      ST_APPEND_REST,
      ST_CHECK,
      ST_WALK,
      ST_EMIT,
      ST_OVERFLOW
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_APPEND_ACTIVE;
            end
         end
         ST_APPEND_ACTIVE: begin
            if (status.full) begin
               state_in = ST_OVERFLOW;
            end else begin
               cmd.append_active = 1'b1;
               state_in = ST_APPEND_REST;
            end
         end
         ST_APPEND_REST: begin
            cmd.append_rest = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.walk_start = 1'b1;
            state_in = status.join_ready ? ST_WALK : ST_IDLE;
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_stop) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_join = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_OVERFLOW: begin
            if (status.out_free) begin
               cmd.emit_overflow = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/psj_datapath.sv =====
// Datapath of the pulse segment joiner: segment buffer, change tracking,
// join accumulators and the result register. Depends on psj_pkg.
module psj_datapath
   import psj_pkg::*;
#(
   parameter int SEGMENTS = SEGMENTS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   input  psj_req_type    req_data,
   input  psj_cmd_type    cmd,
   output psj_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output psj_rsp_type    rsp_data
);

   localparam int CW = $clog2(SEGMENTS + 1);
   localparam int IW = $clog2(SEGMENTS);

   psj_req_type req_ff, req_in;
   logic        lvl_ff [SEGMENTS];
   logic        lvl_in [SEGMENTS];
   logic [15:0] time_ff [SEGMENTS];
   logic [15:0] time_in [SEGMENTS];
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] changes_ff, changes_in;
   logic        last_ff, last_in;
   logic        walk_last_ff, walk_last_in;
   logic        walk_changed_ff, walk_changed_in;
   logic [15:0] sum_all_ff, sum_all_in;
   logic [15:0] sum_high_ff, sum_high_in;
   psj_rsp_type rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   logic        app_en;
   logic        app_lvl;
   logic [15:0] app_time;
   logic        walk_stop;

   assign walk_stop = walk_changed_ff && (lvl_ff[0] != walk_last_ff);

   assign status.full       = (count_ff >= CW'(SEGMENTS - 1));
   assign status.join_ready = (count_ff >= CW'(JOIN_MIN_SEGMENTS)) &&
                              (changes_ff >= CW'(JOIN_CHANGES));
   assign status.walk_stop  = walk_stop;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      app_en   = 1'b0;
      app_lvl  = req_ff.level_high;
      app_time = req_ff.active_time;
      if (cmd.append_active) begin
         app_en = !(!req_ff.level_high && (count_ff == '0));
      end else if (cmd.append_rest) begin
         app_en   = (req_ff.pulse_period > req_ff.active_time);
         app_lvl  = ~req_ff.level_high;
         app_time = req_ff.pulse_period - req_ff.active_time;
      end
   end

   always_comb begin
      req_in          = cmd.capture ? req_data : req_ff;
      lvl_in          = lvl_ff;
      time_in         = time_ff;
      count_in        = count_ff;
      changes_in      = changes_ff;
      last_in         = last_ff;
      walk_last_in    = walk_last_ff;
      walk_changed_in = walk_changed_ff;
      sum_all_in      = sum_all_ff;
      sum_high_in     = sum_high_ff;
      rsp_in          = rsp_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;

      if (app_en) begin
         lvl_in[count_ff[IW-1:0]]  = app_lvl;
         time_in[count_ff[IW-1:0]] = app_time;
         if ((count_ff != '0) && (app_lvl != last_ff)) begin
            changes_in = changes_ff + CW'(1);
         end
         last_in  = app_lvl;
         count_in = count_ff + CW'(1);
      end

      if (cmd.walk_start) begin
         sum_all_in      = '0;
         sum_high_in     = '0;
         walk_last_in    = lvl_ff[0];
         walk_changed_in = 1'b0;
      end

      if (cmd.walk_step) begin
         if (walk_stop) begin
            changes_in = changes_ff - CW'(JOIN_CHANGES);
         end else begin
            if (lvl_ff[0] != walk_last_ff) begin
               walk_changed_in = 1'b1;
               walk_last_in    = lvl_ff[0];
            end
            sum_all_in = sum_all_ff + time_ff[0];
            if (lvl_ff[0]) begin
               sum_high_in = sum_high_ff + time_ff[0];
            end
            for (int j = 0; j < SEGMENTS - 1; j++) begin
               lvl_in[j]  = lvl_ff[j + 1];
               time_in[j] = time_ff[j + 1];
            end
            count_in = count_ff - CW'(1);
         end
      end

      if (cmd.emit_join) begin
         rsp_in.joined_period = sum_all_ff;
         rsp_in.joined_high   = sum_high_ff;
         rsp_in.overflow      = 1'b0;
         rsp_valid_in         = 1'b1;
      end else if (cmd.emit_overflow) begin
         rsp_in.joined_period = '0;
         rsp_in.joined_high   = '0;
         rsp_in.overflow      = 1'b1;
         rsp_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      req_ff          <= req_in;
      lvl_ff          <= lvl_in;
      time_ff         <= time_in;
      last_ff         <= last_in;
      walk_last_ff    <= walk_last_in;
      walk_changed_ff <= walk_changed_in;
      sum_all_ff      <= sum_all_in;
      sum_high_ff     <= sum_high_in;
      rsp_ff          <= rsp_in;
      if (reset) begin
         count_ff     <= '0;
         changes_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         changes_ff   <= changes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/pulse_segment_joiner_unit.sv =====
// Top level of the pulse segment joiner; depends on psj_pkg, psj_ctrl and psj_datapath.
// After acceptance, a transaction appends its active and rest segments, then checks
// for a join; with no join it ends without a result. A full buffer gives an overflow
// result instead, and a join walks the buffer, summing segments until the walk stops.
// One transaction is in work at a time; a new one is taken only back in idle.
// Reset is synchronous and active high and empties the segment buffer.
module pulse_segment_joiner_unit
   import psj_pkg::*;
#(
   parameter int SEGMENTS = SEGMENTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  psj_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output psj_rsp_type rsp_data
);

   psj_cmd_type    cmd;
   psj_status_type status;

   psj_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   psj_datapath #(
      .SEGMENTS (SEGMENTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.overflow) |->
         (rsp_data.joined_period == '0) && (rsp_data.joined_high == '0))
      else $error("Overflow result carries nonzero sums.");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("Second transaction accepted while one is in work.");

   a_emit_when_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_join || cmd.emit_overflow) |-> status.out_free)
      else $error("Result register loaded while still occupied.");

endmodule
